// ===== rtl/ubxfp_pkg.sv =====
// Shared types and constants for the binary frame parser.
package ubxfp_pkg;

	// Sync pattern that opens every frame
	localparam logic [7:0] SYNC_FIRST  = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;

	// Input command codes
	localparam logic CMD_RX   = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// Result kind codes
	localparam logic RK_FRAME = 1'b0;
	localparam logic RK_READ  = 1'b1;

	// Parser phases
	typedef enum logic [3:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_CLASS,
		PH_ID,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAYLOAD,
		PH_CK_A,
		PH_CK_B
	} phase_t;

	// Frame status from the parser to the result path
	typedef struct packed {
		logic       done;       // good frame completes with this transaction
		logic       good_half;  // store half holding the published payload
		logic [7:0] good_class;
		logic [7:0] good_id;
		logic [7:0] rx_class;   // values being published when done is high
		logic [7:0] rx_id;
	} frame_info_t;

endpackage

// ===== rtl/ubxfp_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module ubxfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ubxfp_parser.sv =====
// Frame parse state machine, Fletcher-8 check and payload store write port.
module ubxfp_parser #(
	parameter int MAX_PAYLOAD = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 byte_valid,
	input  logic [7:0]                           rx_byte,
	output logic                                 wr_en,
	output logic [$clog2(2*MAX_PAYLOAD)-1:0]     wr_addr,
	output logic [7:0]                           wr_data,
	output ubxfp_pkg::frame_info_t               info,
	output logic [$clog2(MAX_PAYLOAD+1)-1:0]     good_length,
	output logic [$clog2(MAX_PAYLOAD+1)-1:0]     rx_length
);

	import ubxfp_pkg::*;

	localparam int LW = $clog2(MAX_PAYLOAD + 1);
	localparam int AW = $clog2(2 * MAX_PAYLOAD);

	phase_t phase_q, phase_d;

	logic [7:0]    rx_class_q, rx_id_q;
	logic [15:0]   rx_length_q;
	logic [LW-1:0] bytes_q;
	logic [7:0]    sum_a_q, sum_b_q;
	logic          half_q;
	logic [7:0]    good_class_q, good_id_q;
	logic [LW-1:0] good_length_q;

	logic          sum_clr, sum_en, ld_class, ld_id, ld_lo, ld_hi, cnt_clr, cnt_inc, publish;
	logic [15:0]   len_full;
	logic [LW-1:0] cnt_next;
	logic [7:0]    sum_a_next, sum_b_next;

	assign len_full   = {rx_byte, rx_length_q[7:0]};
	assign cnt_next   = bytes_q + LW'(1);
	assign sum_a_next = sum_a_q + rx_byte;
	assign sum_b_next = sum_b_q + sum_a_next;

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Next phase and datapath strobes
	always_comb begin
		phase_d  = phase_q;
		wr_en    = 1'b0;
		sum_clr  = 1'b0;
		sum_en   = 1'b0;
		ld_class = 1'b0;
		ld_id    = 1'b0;
		ld_lo    = 1'b0;
		ld_hi    = 1'b0;
		cnt_clr  = 1'b0;
		cnt_inc  = 1'b0;
		publish  = 1'b0;
		if (byte_valid) begin
			unique case (phase_q)
				PH_HUNT1: begin
					if (rx_byte == SYNC_FIRST) phase_d = PH_HUNT2;
				end
				PH_HUNT2: begin
					if (rx_byte == SYNC_SECOND) begin
						sum_clr = 1'b1;
						phase_d = PH_CLASS;
					end else begin
						phase_d = PH_HUNT1;
					end
				end
				PH_CLASS: begin
					ld_class = 1'b1;
					sum_en   = 1'b1;
					phase_d  = PH_ID;
				end
				PH_ID: begin
					ld_id   = 1'b1;
					sum_en  = 1'b1;
					phase_d = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					ld_lo   = 1'b1;
					sum_en  = 1'b1;
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					ld_hi   = 1'b1;
					sum_en  = 1'b1;
					cnt_clr = 1'b1;
					if (len_full > 16'(MAX_PAYLOAD)) begin
						phase_d = PH_HUNT1;
					end else if (len_full == 16'd0) begin
						phase_d = PH_CK_A;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					wr_en   = 1'b1;
					sum_en  = 1'b1;
					cnt_inc = 1'b1;
					if (cnt_next >= rx_length_q[LW-1:0]) phase_d = PH_CK_A;
				end
				PH_CK_A: begin
					phase_d = (rx_byte == sum_a_q) ? PH_CK_B : PH_HUNT1;
				end
				PH_CK_B: begin
					phase_d = PH_HUNT1;
					publish = (rx_byte == sum_b_q);
				end
				default: begin
					phase_d = PH_HUNT1;
				end
			endcase
		end
	end

	// Control state: published half, header of the last good frame, and the header, byte count and checksums in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q        <= 1'b0;
			good_class_q  <= '0;
			good_id_q     <= '0;
			good_length_q <= '0;
			rx_class_q    <= '0;
			rx_id_q       <= '0;
			rx_length_q   <= '0;
			bytes_q       <= '0;
			sum_a_q       <= '0;
			sum_b_q       <= '0;
		end else begin
			if (publish) begin
				half_q        <= ~half_q;
				good_class_q  <= rx_class_q;
				good_id_q     <= rx_id_q;
				good_length_q <= rx_length_q[LW-1:0];
			end
			if (ld_class) rx_class_q <= rx_byte;
			if (ld_id) rx_id_q <= rx_byte;
			if (ld_lo) rx_length_q <= {8'h00, rx_byte};
			if (ld_hi) rx_length_q <= len_full;
			if (cnt_clr) begin
				bytes_q <= '0;
			end else if (cnt_inc) begin
				bytes_q <= cnt_next;
			end
			if (sum_clr) begin
				sum_a_q <= '0;
				sum_b_q <= '0;
			end else if (sum_en) begin
				sum_a_q <= sum_a_next;
				sum_b_q <= sum_b_next;
			end
		end
	end

	// Payload goes to the half that is not published
	assign wr_addr = AW'(bytes_q) + (half_q ? AW'(0) : AW'(MAX_PAYLOAD));
	assign wr_data = rx_byte;

	assign info.done       = publish;
	assign info.good_half  = half_q;
	assign info.good_class = good_class_q;
	assign info.good_id    = good_id_q;
	assign info.rx_class   = rx_class_q;
	assign info.rx_id      = rx_id_q;
	assign good_length     = good_length_q;
	assign rx_length       = rx_length_q[LW-1:0];

	// A good frame always swaps the published half
	a_publish_swaps: assert property (@(posedge clk) disable iff (!arst_n)
		publish |=> half_q != $past(half_q))
		else $error("published half did not swap on good frame");

	// Payload writes only reach a length that passed the limit check
	a_write_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (bytes_q < rx_length_q[LW-1:0]) && (rx_length_q <= 16'(MAX_PAYLOAD)))
		else $error("payload write beyond frame length");

	// Checksum B is only entered from checksum A; it may be held while reads go by
	a_ck_b_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_q == PH_CK_B) |-> $past(phase_q) == PH_CK_A)
		else $error("checksum B phase entered out of order");

endmodule

// ===== rtl/ubx_frame_parser_core.sv =====
// Top level: frame parser, ping-pong payload RAM and two-stage result path.
//
// The block accepts one transaction per cycle while in_ready is high, received byte
// or payload read alike, and each produces its result, if any, through the registered
// read of the payload RAM and stage 1, then the output register. Every transaction
// makes at most one RAM access, a write for a payload byte or a read for a read
// command, so the single write and single read port of the 2*MAX_PAYLOAD byte RAM
// allow one item per cycle when not stalled. Reads go to the published half and
// writes to the other one, so they never meet on an entry. The RAM needs no
// clearing pass after reset; only entries of a checked frame are ever read.
module ubx_frame_parser_core #(
	parameter int MAX_PAYLOAD = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic [7:0] rx_byte,
	input  logic [7:0] read_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       result_kind,
	output logic [7:0] frame_class,
	output logic [7:0] frame_id,
	output logic [8:0] frame_length,
	output logic [7:0] read_data
);

	import ubxfp_pkg::*;

	localparam int LW = $clog2(MAX_PAYLOAD + 1);
	localparam int AW = $clog2(2 * MAX_PAYLOAD);
	localparam int CW = (LW > 8) ? LW : 8;

	logic          accept, adv, rd_en, in_range;
	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data, ram_rdata;
	frame_info_t   info;
	logic [LW-1:0] good_length, rx_length;

	logic          valid_s1, kind_s1, hit_s1;
	logic [7:0]    class_s1, id_s1;
	logic [LW-1:0] length_s1;

	logic          out_valid_q, out_kind_q;
	logic [7:0]    out_class_q, out_id_q, out_data_q;
	logic [LW-1:0] out_length_q;

	// Handshake: stage 1 moves on whenever the output register is free or drained
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;

	ubxfp_parser #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (accept && (command == CMD_RX)),
		.rx_byte    (rx_byte),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.info       (info),
		.good_length(good_length),
		.rx_length  (rx_length)
	);

	// Read address in the published half
	assign rd_en    = accept && (command == CMD_READ);
	assign rd_addr  = AW'(read_index) + (info.good_half ? AW'(MAX_PAYLOAD) : AW'(0));
	assign in_range = CW'(read_index) < CW'(good_length);

	ubxfp_ram #(
		.WIDTH(8),
		.DEPTH(2 * MAX_PAYLOAD)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// Stage 1: header snapshot while the RAM read is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept && ((command == CMD_READ) || info.done);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (command == CMD_READ) begin
				kind_s1   <= RK_READ;
				hit_s1    <= in_range;
				class_s1  <= info.good_class;
				id_s1     <= info.good_id;
				length_s1 <= good_length;
			end else begin
				kind_s1   <= RK_FRAME;
				hit_s1    <= 1'b0;
				class_s1  <= info.rx_class;
				id_s1     <= info.rx_id;
				length_s1 <= rx_length;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_kind_q   <= kind_s1;
			out_class_q  <= class_s1;
			out_id_q     <= id_s1;
			out_length_q <= length_s1;
			out_data_q   <= hit_s1 ? ram_rdata : 8'h00;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_kind  = out_kind_q;
	assign frame_class  = out_class_q;
	assign frame_id     = out_id_q;
	assign frame_length = 9'(out_length_q);
	assign read_data    = out_data_q;

	// A frame result never carries read data
	a_frame_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_kind_q == RK_FRAME) |-> out_data_q == 8'h00)
		else $error("frame result with non-zero read data");

	// RAM is never written and read by the same transaction
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("payload RAM written and read in the same cycle");

	// A stalled stage 1 holds and issues no new read, so RAM data stays valid
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(class_s1) && $stable(kind_s1)
			&& $stable(ram_rdata))
		else $error("stage 1 lost its transaction while stalled");

	// An empty output register never blocks input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");

endmodule
